// File: rtl/can_mbx_pkg.sv
// ----------------------------------------------------------------------------
// can_mbx_pkg
// Shared types, sizes and codes for the CAN mailbox receive FIFO block.
// ----------------------------------------------------------------------------
`default_nettype none

package can_mbx_pkg;

    localparam int NUM_OBJECTS = 32;
    localparam int FIFO_DEPTH  = 32;

    localparam int IDX_W  = (NUM_OBJECTS > 1) ? $clog2(NUM_OBJECTS) : 1;
    localparam int HEAD_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int STORE_DEPTH = NUM_OBJECTS * FIFO_DEPTH;
    localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    localparam logic [1:0] MODE_PROGRAM = 2'd0;
    localparam logic [1:0] MODE_RECEIVE = 2'd1;
    localparam logic [1:0] MODE_READ    = 2'd2;
    localparam logic [1:0] MODE_SEND    = 2'd3;

    localparam logic [3:0] OUT_QUEUED        = 4'd0;
    localparam logic [3:0] OUT_OVERWRITE     = 4'd1;
    localparam logic [3:0] OUT_NO_MATCH      = 4'd2;
    localparam logic [3:0] OUT_BAD_FRAME     = 4'd3;
    localparam logic [3:0] OUT_READ_OK       = 4'd4;
    localparam logic [3:0] OUT_EMPTY         = 4'd5;
    localparam logic [3:0] OUT_PROGRAMMED    = 4'd6;
    localparam logic [3:0] OUT_SENT          = 4'd7;
    localparam logic [3:0] OUT_SEND_REJECTED = 4'd8;

    localparam logic [3:0] FRAME_BYTES = 4'd8;

    typedef struct packed {
        logic [1:0]  mode;
        logic [4:0]  object;
        logic [10:0] can_id;
        logic        is_extended;
        logic        is_remote;
        logic        is_error;
        logic [3:0]  length;
        logic [63:0] payload;
        logic        module_select;
    } mbx_req_t;

    typedef struct packed {
        logic [3:0]  outcome;
        logic [63:0] read_payload;
        logic        tx_valid;
        logic [10:0] tx_id;
        logic [63:0] tx_payload;
        logic [4:0]  matched_object;
    } mbx_rsp_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic read_done;
    } mbx_cmd_t;

    typedef struct packed {
        logic read_hit;
    } mbx_status_t;

endpackage

`default_nettype wire

// File: rtl/can_mbx_ram.sv
// ----------------------------------------------------------------------------
// can_mbx_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module can_mbx_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/can_mbx_ctrl.sv
// ----------------------------------------------------------------------------
// can_mbx_ctrl
// Sequencer: takes one request, commits it, waits on the payload memory for
// reads and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module can_mbx_ctrl (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     req_valid,
    output logic                          req_stall,
    output logic                          rsp_valid,
    input  wire logic                     rsp_stall,
    output can_mbx_pkg::mbx_cmd_t         cmd,
    input  wire can_mbx_pkg::mbx_status_t status
);

    import can_mbx_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    logic       out_free;

    // output slot is empty or its transfer completes this cycle
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    cmd.exec = 1'b1;
                    if (status.read_hit)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        rsp_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
            end
            S_READ:
            begin
                cmd.read_done  = 1'b1;
                rsp_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> state_reg == S_EXEC)
        else $error("accepted request did not move to exec");

    a_read_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |-> $past(state_reg) == S_EXEC)
        else $error("read wait entered from wrong state");

    a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |-> !rsp_valid_reg)
        else $error("read data lands on an occupied output slot");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg) != S_IDLE)
        else $error("result appeared without a request in flight");

endmodule

`default_nettype wire

// File: rtl/can_mbx_datapath.sv
// ----------------------------------------------------------------------------
// can_mbx_datapath
// Object identifier table, per-object ring pointers, payload store and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module can_mbx_datapath (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire can_mbx_pkg::mbx_req_t    req,
    output can_mbx_pkg::mbx_rsp_t         rsp,
    input  wire can_mbx_pkg::mbx_cmd_t    cmd,
    output can_mbx_pkg::mbx_status_t      status
);

    import can_mbx_pkg::*;

    mbx_req_t               item_reg;
    logic [NUM_OBJECTS-1:0] hit_reg;
    logic [10:0]            id_table_reg [NUM_OBJECTS];
    logic [HEAD_W-1:0]      head_reg     [NUM_OBJECTS];
    logic [CNT_W-1:0]       count_reg    [NUM_OBJECTS];
    mbx_rsp_t               rsp_reg;

    logic [NUM_OBJECTS-1:0] match;
    logic [NUM_OBJECTS-1:0] hit_lowest;
    logic [IDX_W-1:0]       hit_idx;
    logic                   hit_any;
    logic [IDX_W-1:0]       obj_idx;
    logic                   obj_in_range;
    logic [IDX_W-1:0]       sel_idx;
    logic [HEAD_W-1:0]      head_sel;
    logic [CNT_W-1:0]       count_sel;
    logic                   full;
    logic [HEAD_W-1:0]      head_inc;
    logic [SUM_W-1:0]       tail_sum;
    logic [HEAD_W-1:0]      tail;
    logic [HEAD_W-1:0]      slot;
    logic [ADDR_W-1:0]      ram_addr;
    logic                   bad_frame;
    logic                   do_queue;
    logic                   do_pop;
    logic                   do_program;
    logic                   send_ok;
    logic [63:0]            ram_q;
    mbx_rsp_t               rsp_comb;

    // identifier compare at accept, keep only the lowest-numbered hit
    always_comb
    begin
        for (int k = 0; k < NUM_OBJECTS; k++)
        begin
            match[k] = (id_table_reg[k] == req.can_id);
        end
        hit_lowest = match & (~match + NUM_OBJECTS'(1));
    end

    // hit vector is one-hot, so the index is a plain or of the positions
    always_comb
    begin
        hit_idx = '0;
        for (int k = 0; k < NUM_OBJECTS; k++)
        begin
            if (hit_reg[k])
            begin
                hit_idx = hit_idx | IDX_W'(k);
            end
        end
    end

    assign hit_any      = |hit_reg;
    assign obj_idx      = IDX_W'(item_reg.object);
    assign obj_in_range = int'(item_reg.object) < NUM_OBJECTS;
    assign sel_idx      = (item_reg.mode == MODE_RECEIVE) ? hit_idx : obj_idx;
    assign head_sel     = head_reg[sel_idx];
    assign count_sel    = count_reg[sel_idx];
    assign full         = (count_sel == CNT_W'(FIFO_DEPTH));
    assign head_inc     = (head_sel == HEAD_W'(FIFO_DEPTH - 1)) ? '0
                                                               : head_sel + HEAD_W'(1);
    assign tail_sum     = SUM_W'(head_sel) + SUM_W'(count_sel);
    assign tail         = (tail_sum >= SUM_W'(FIFO_DEPTH))
                          ? HEAD_W'(tail_sum - SUM_W'(FIFO_DEPTH))
                          : HEAD_W'(tail_sum);
    // on overwrite the oldest slot is reused
    assign slot         = (do_queue && !full) ? tail : head_sel;
    assign ram_addr     = ADDR_W'(sel_idx * FIFO_DEPTH) + ADDR_W'(slot);

    assign bad_frame  = item_reg.is_extended || item_reg.is_remote || item_reg.is_error
                        || (item_reg.length != FRAME_BYTES);
    assign do_queue   = (item_reg.mode == MODE_RECEIVE) && !bad_frame && hit_any;
    assign do_pop     = (item_reg.mode == MODE_READ) && obj_in_range
                        && (count_sel != '0);
    assign do_program = (item_reg.mode == MODE_PROGRAM) && obj_in_range;
    assign send_ok    = !item_reg.module_select && obj_in_range
                        && (item_reg.length == FRAME_BYTES);

    assign status.read_hit = do_pop;

    always_comb
    begin
        rsp_comb = '0;
        case (item_reg.mode)
            MODE_PROGRAM:
            begin
                rsp_comb.outcome = OUT_PROGRAMMED;
            end
            MODE_RECEIVE:
            begin
                if (bad_frame)
                begin
                    rsp_comb.outcome = OUT_BAD_FRAME;
                end
                else if (!hit_any)
                begin
                    rsp_comb.outcome = OUT_NO_MATCH;
                end
                else
                begin
                    rsp_comb.outcome        = full ? OUT_OVERWRITE : OUT_QUEUED;
                    rsp_comb.matched_object = 5'(hit_idx);
                end
            end
            MODE_READ:
            begin
                rsp_comb.outcome = OUT_EMPTY;
            end
            MODE_SEND:
            begin
                if (send_ok)
                begin
                    rsp_comb.outcome    = OUT_SENT;
                    rsp_comb.tx_valid   = 1'b1;
                    rsp_comb.tx_id      = id_table_reg[obj_idx];
                    rsp_comb.tx_payload = item_reg.payload;
                end
                else
                begin
                    rsp_comb.outcome = OUT_SEND_REJECTED;
                end
            end
            default:
            begin
                rsp_comb = '0;
            end
        endcase
    end

    can_mbx_ram #(
        .WIDTH (64),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.exec && do_queue),
        .wr_addr (ram_addr),
        .wr_data (item_reg.payload),
        .rd_en   (cmd.exec && do_pop),
        .rd_addr (ram_addr),
        .rd_data (ram_q)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= req;
            hit_reg  <= hit_lowest;
        end
        if (cmd.exec && !do_pop)
        begin
            rsp_reg <= rsp_comb;
        end
        else if (cmd.read_done)
        begin
            rsp_reg <= '{outcome: OUT_READ_OK, read_payload: ram_q, default: '0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_OBJECTS; k++)
            begin
                id_table_reg[k] <= '0;
                head_reg[k]     <= '0;
                count_reg[k]    <= '0;
            end
        end
        else if (cmd.exec)
        begin
            if (do_program)
            begin
                id_table_reg[obj_idx] <= item_reg.can_id;
            end
            if (do_queue)
            begin
                if (full)
                begin
                    head_reg[sel_idx] <= head_inc;
                end
                else
                begin
                    count_reg[sel_idx] <= count_sel + CNT_W'(1);
                end
            end
            if (do_pop)
            begin
                head_reg[sel_idx]  <= head_inc;
                count_reg[sel_idx] <= count_sel - CNT_W'(1);
            end
        end
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

// File: rtl/can_mailbox_receive_fifo.sv
// ----------------------------------------------------------------------------
// can_mailbox_receive_fifo
// CAN message-object mailbox: identifier programming, acceptance filtering
// into per-object ring FIFOs, FIFO reads and transmit requests.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request (program, received frame, read, send); it
//   transfers when req_valid is high and req_stall is low.
//   rsp carries exactly one result per request; it transfers when rsp_valid
//   is high and rsp_stall is low.
//   A request passes from transfer to result through accept and identifier
//   compare, then commit; a successful read adds the registered read of the
//   payload memory. One request is in flight at a time, so a new request is
//   accepted only once the previous one has produced its result.
//   The result register holds a finished result while a new request is
//   accepted; a stalled rsp holds the next request at its commit step.
//   Reset clears the identifier table and all FIFO pointers and counts at
//   once; the payload memory is not cleared and is only read at written
//   entries.
// ----------------------------------------------------------------------------
`default_nettype none

module can_mailbox_receive_fifo (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    output logic                       req_stall,
    input  wire can_mbx_pkg::mbx_req_t req,
    output logic                       rsp_valid,
    input  wire logic                  rsp_stall,
    output can_mbx_pkg::mbx_rsp_t      rsp
);

    import can_mbx_pkg::*;

    mbx_cmd_t    cmd;
    mbx_status_t status;

    can_mbx_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .status    (status)
    );

    can_mbx_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .rsp    (rsp),
        .cmd    (cmd),
        .status (status)
    );

endmodule

`default_nettype wire

// File: tb/can_mailbox_receive_fifo_test.sv
// ----------------------------------------------------------------------------
// can_mailbox_receive_fifo_test
// Self-checking testbench for the CAN mailbox receive FIFO. Requests are
// driven through the valid/stall request channel while a shadow copy of the
// identifier table and per-object ring FIFOs predicts every result. Each
// response transfer is checked field by field against the oldest prediction.
// Directed cases cover the special frames, then FIFO overwrite runs, a long
// receiver hold-off, and random traffic with random idling on both sides.
// ----------------------------------------------------------------------------

module can_mailbox_receive_fifo_test;

    timeunit 1ns;
    timeprecision 1ps;

    import can_mbx_pkg::*;

    localparam int RANDOM_ITEMS   = 1800;
    localparam int CHUNK_ITEMS    = 200;
    localparam int HOLD_CYCLES    = 120;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int POOL_SIZE      = 8;

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_stall;
    mbx_req_t req;
    logic     rsp_valid;
    logic     rsp_stall;
    mbx_rsp_t rsp;

    // shadow state of the mailbox
    logic [10:0]       id_tbl    [NUM_OBJECTS] = '{default: '0};
    logic [63:0]       fifo_data [NUM_OBJECTS][FIFO_DEPTH];
    logic [HEAD_W-1:0] fifo_head [NUM_OBJECTS] = '{default: '0};
    logic [CNT_W-1:0]  fifo_cnt  [NUM_OBJECTS] = '{default: '0};

    mbx_rsp_t    pending_rsp_q[$];
    logic [10:0] id_pool [POOL_SIZE];

    bit failed        = 1'b0;
    bit tx_idle_on    = 1'b1;
    bit rx_idle_on    = 1'b1;
    bit hold_rsp_req  = 1'b0;

    can_mailbox_receive_fifo DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic mbx_rsp_t predict_mailbox_rsp(input mbx_req_t r);
        mbx_rsp_t o;
        int       k;
        int       tail;
        o = '0;
        case (r.mode)
            MODE_PROGRAM:
            begin
                if (r.object < NUM_OBJECTS)
                    id_tbl[r.object] = r.can_id;
                o.outcome = OUT_PROGRAMMED;
            end
            MODE_RECEIVE:
            begin
                if (r.is_extended || r.is_remote || r.is_error || r.length != FRAME_BYTES)
                begin
                    o.outcome = OUT_BAD_FRAME;
                end
                else
                begin
                    // lowest-numbered matching object wins
                    k = NUM_OBJECTS;
                    for (int i = NUM_OBJECTS - 1; i >= 0; i--)
                        if (id_tbl[i] == r.can_id)
                            k = i;
                    if (k == NUM_OBJECTS)
                    begin
                        o.outcome = OUT_NO_MATCH;
                    end
                    else
                    begin
                        o.outcome = OUT_QUEUED;
                        if (fifo_cnt[k] >= FIFO_DEPTH)
                        begin
                            fifo_head[k] = HEAD_W'((fifo_head[k] + 1) % FIFO_DEPTH);
                            fifo_cnt[k]  = fifo_cnt[k] - 1'b1;
                            o.outcome    = OUT_OVERWRITE;
                        end
                        tail = (fifo_head[k] + fifo_cnt[k]) % FIFO_DEPTH;
                        fifo_data[k][tail] = r.payload;
                        fifo_cnt[k]        = fifo_cnt[k] + 1'b1;
                        o.matched_object   = 5'(k);
                    end
                end
            end
            MODE_READ:
            begin
                if (r.object >= NUM_OBJECTS || fifo_cnt[r.object] == 0)
                begin
                    o.outcome = OUT_EMPTY;
                end
                else
                begin
                    o.read_payload      = fifo_data[r.object][fifo_head[r.object]];
                    fifo_head[r.object] = HEAD_W'((fifo_head[r.object] + 1) % FIFO_DEPTH);
                    fifo_cnt[r.object]  = fifo_cnt[r.object] - 1'b1;
                    o.outcome           = OUT_READ_OK;
                end
            end
            default:
            begin
                if (r.module_select || r.object >= NUM_OBJECTS || r.length != FRAME_BYTES)
                begin
                    o.outcome = OUT_SEND_REJECTED;
                end
                else
                begin
                    o.outcome    = OUT_SENT;
                    o.tx_valid   = 1'b1;
                    o.tx_id      = id_tbl[r.object];
                    o.tx_payload = r.payload;
                end
            end
        endcase
        return o;
    endfunction

    function automatic logic [63:0] random_payload();
        return {$urandom, $urandom};
    endfunction

    function automatic mbx_req_t req_of(input logic [1:0] mode, input logic [4:0] obj,
                                        input logic [10:0] id, input logic [3:0] len,
                                        input logic [63:0] data);
        mbx_req_t q;
        q               = '0;
        q.mode          = mode;
        q.object        = obj;
        q.can_id        = id;
        q.length        = len;
        q.payload       = data;
        return q;
    endfunction

    // prefer objects that hold data so reads mostly pop something
    function automatic logic [4:0] filled_object();
        int start;
        int k;
        start = $urandom_range(0, NUM_OBJECTS - 1);
        for (int i = 0; i < NUM_OBJECTS; i++)
        begin
            k = (start + i) % NUM_OBJECTS;
            if (fifo_cnt[k] != 0)
                return 5'(k);
        end
        return 5'(start);
    endfunction

    function automatic mbx_req_t random_req();
        mbx_req_t q;
        int       pick;
        q.mode          = 2'($urandom_range(0, 3));
        q.object        = 5'($urandom_range(0, 31));
        q.can_id        = 11'($urandom_range(0, 2047));
        q.is_extended   = 1'($urandom_range(0, 1));
        q.is_remote     = 1'($urandom_range(0, 1));
        q.is_error      = 1'($urandom_range(0, 1));
        q.length        = 4'($urandom_range(0, 15));
        q.payload       = random_payload();
        q.module_select = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 15)
        begin
            q.mode = MODE_PROGRAM;
            if ($urandom_range(0, 4) != 0)
                q.can_id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        else if (pick < 55)
        begin
            q.mode = MODE_RECEIVE;
            if ($urandom_range(0, 3) != 0)
            begin
                q.is_extended = 1'b0;
                q.is_remote   = 1'b0;
                q.is_error    = 1'b0;
                q.length      = FRAME_BYTES;
                if ($urandom_range(0, 6) != 0)
                    q.can_id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
            end
        end
        else if (pick < 80)
        begin
            q.mode = MODE_READ;
            if ($urandom_range(0, 3) != 0)
                q.object = filled_object();
        end
        else
        begin
            q.mode = MODE_SEND;
            if ($urandom_range(0, 3) != 0)
            begin
                q.module_select = 1'b0;
                q.length        = FRAME_BYTES;
            end
        end
        return q;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int idle_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_req(input mbx_req_t item);
        int gap;
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall !== 1'b0)
            @(posedge clk);
        pending_rsp_q.push_back(predict_mailbox_rsp(item));
        gap = 0;
        if (tx_idle_on && $urandom_range(0, 1) == 0)
            gap = idle_len();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_rsp_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed_cases();
        mbx_req_t m;
        // identifier 0 matches object 0 straight out of reset
        send_req(req_of(MODE_RECEIVE, 5'd0, 11'd0, FRAME_BYTES, '1));
        send_req(req_of(MODE_READ, 5'd0, 11'd0, 4'd0, '0));
        send_req(req_of(MODE_READ, 5'd0, 11'd0, 4'd0, '0));
        send_req(req_of(MODE_PROGRAM, 5'd31, 11'h7FF, 4'd0, '0));
        send_req(req_of(MODE_PROGRAM, 5'd0, 11'h001, 4'd15, '1));
        send_req(req_of(MODE_RECEIVE, 5'd0, 11'h7FF, FRAME_BYTES, '0));
        // frames dropped by the flag and length filter
        m = req_of(MODE_RECEIVE, 5'd31, 11'h7FF, FRAME_BYTES, random_payload());
        m.is_extended = 1'b1;
        send_req(m);
        m.is_extended = 1'b0;
        m.is_remote   = 1'b1;
        send_req(m);
        m.is_remote = 1'b0;
        m.is_error  = 1'b1;
        send_req(m);
        m.is_error = 1'b0;
        m.length   = 4'd0;
        send_req(m);
        m.length = 4'd15;
        send_req(m);
        m.length = 4'd7;
        send_req(m);
        send_req(req_of(MODE_RECEIVE, 5'd0, 11'h123, FRAME_BYTES, random_payload()));
        send_req(req_of(MODE_READ, 5'd31, 11'd0, 4'd0, '0));
        // transmit path and its rejections
        send_req(req_of(MODE_SEND, 5'd31, 11'd0, FRAME_BYTES, random_payload()));
        m = req_of(MODE_SEND, 5'd31, 11'd0, FRAME_BYTES, random_payload());
        m.module_select = 1'b1;
        send_req(m);
        send_req(req_of(MODE_SEND, 5'd31, 11'd0, 4'd15, random_payload()));
        send_req(req_of(MODE_SEND, 5'd31, 11'd0, 4'd0, random_payload()));
        send_req(req_of(MODE_SEND, 5'd0, 11'h7FF, FRAME_BYTES, '1));
        send_req(req_of(MODE_READ, 5'd5, 11'd0, 4'd0, '0));
        // object 0 moved away, so identifier 0 now lands in object 1
        send_req(req_of(MODE_RECEIVE, 5'd0, 11'd0, FRAME_BYTES, 64'hAAAA_5555_AAAA_5555));
        send_req(req_of(MODE_READ, 5'd1, 11'd0, 4'd0, '0));
    endtask

    task automatic test_fifo_overwrite();
        int          k;
        int          n;
        bit          taken;
        logic [10:0] id;
        for (int j = 0; j < 2; j++)
        begin
            k     = (j == 0) ? 0 : NUM_OBJECTS - 1;
            taken = 1'b1;
            id    = '0;
            // pick an identifier that no lower object already claims
            while (taken)
            begin
                id    = 11'($urandom_range(0, 2047));
                taken = 1'b0;
                for (int i = 0; i < k; i++)
                    if (id_tbl[i] == id)
                        taken = 1'b1;
            end
            send_req(req_of(MODE_PROGRAM, 5'(k), id, FRAME_BYTES, '0));
            n = FIFO_DEPTH + $urandom_range(1, 12);
            repeat (n)
                send_req(req_of(MODE_RECEIVE, 5'(k), id, FRAME_BYTES, random_payload()));
            repeat (FIFO_DEPTH + 1)
                send_req(req_of(MODE_READ, 5'(k), 11'd0, 4'd0, '0));
        end
    endtask

    task automatic test_backpressure();
        for (int i = 0; i < POOL_SIZE; i++)
            id_pool[i] = 11'($urandom_range(0, 2047));
        tx_idle_on   = 1'b0;
        hold_rsp_req = 1'b1;
        repeat (16) send_req(random_req());
        // sender stops until every outstanding result is back
        wait_drained();
        repeat (8) send_req(random_req());
        tx_idle_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        for (int chunk = 0; chunk < RANDOM_ITEMS / CHUNK_ITEMS; chunk++)
        begin
            tx_idle_on = (chunk % 4 != 1);
            rx_idle_on = (chunk % 4 != 2);
            for (int i = 0; i < POOL_SIZE; i++)
            begin
                id_pool[i] = 11'($urandom_range(0, 2047));
                send_req(req_of(MODE_PROGRAM, 5'($urandom_range(0, 31)), id_pool[i],
                                4'($urandom_range(0, 15)), random_payload()));
            end
            repeat (CHUNK_ITEMS) send_req(random_req());
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
            failed = 1'b1;
        end
    endtask

    // response checker
    initial
    begin
        mbx_rsp_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
            begin
                if (pending_rsp_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, rsp);
                    failed = 1'b1;
                end
                else
                begin
                    want = pending_rsp_q.pop_front();
                    check_field("outcome", 64'(want.outcome), 64'(rsp.outcome));
                    check_field("read_payload", want.read_payload, rsp.read_payload);
                    check_field("tx_valid", 64'(want.tx_valid), 64'(rsp.tx_valid));
                    check_field("tx_id", 64'(want.tx_id), 64'(rsp.tx_id));
                    check_field("tx_payload", want.tx_payload, rsp.tx_payload);
                    check_field("matched_object", 64'(want.matched_object),
                                64'(rsp.matched_object));
                end
            end
        end
    end

    // receiver stall pattern
    initial
    begin
        int stall_left;
        stall_left = 0;
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_rsp_req)
            begin
                hold_rsp_req = 1'b0;
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rsp_stall <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                rsp_stall <= 1'b1;
                stall_left--;
            end
            else if (rx_idle_on && $urandom_range(0, 3) == 0)
            begin
                rsp_stall <= 1'b1;
                stall_left = idle_len() - 1;
            end
            else
            begin
                rsp_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles without any transfer
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid === 1'b1 && req_stall === 1'b0) ||
                (rsp_valid === 1'b1 && rsp_stall === 1'b0))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("can_mailbox_receive_fifo regression: fail");
        $finish;
    end

    initial
    begin
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_fifo_overwrite();
        test_backpressure();
        test_random_traffic();

        wait_drained();
        repeat (10) @(posedge clk);
        if (!failed && pending_rsp_q.size() == 0)
            $display("can_mailbox_receive_fifo regression: pass");
        else
            $display("can_mailbox_receive_fifo regression: fail");
        $finish;
    end

endmodule
